/* rtl/speck96_144_block_cipher_macros.svh */
// Assertion helpers for the Speck 96/144 block.
`ifndef SPECK96_144_BLOCK_CIPHER_MACROS_SVH
`define SPECK96_144_BLOCK_CIPHER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define SPK_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("speck96_144 check failed");
// Next-cycle implication
`define SPK_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("speck96_144 check failed");
`else
`define SPK_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define SPK_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* rtl/spk_pkg.sv */
package spk_pkg;

   localparam int ROUNDS    = 29;
   localparam int WORD_BITS = 48;
   localparam int CNT_BITS  = $clog2(ROUNDS);
   localparam int IDX_BITS  = 2;

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [CNT_BITS-1:0]  cnt_type;

   typedef enum logic {
      OP_ENCRYPT = 1'b0,
      OP_DECRYPT = 1'b1
   } op_type;

   typedef enum logic [IDX_BITS-1:0] {
      REG_KEY0 = 2'd0,
      REG_KEY1 = 2'd1,
      REG_KEY2 = 2'd2
   } reg_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXPAND,
      ST_PREP,
      ST_RUN,
      ST_HOLD
   } state_type;

   // Controls from the sequencer to the datapath
   typedef struct packed {
      logic    exp_step;
      logic    run_step;
      logic    decrypt;
      logic    out_load;
      logic    out_from_rnd;
      logic    set_ready;
      logic    ram_we;
      logic    wr_key0;
      cnt_type ram_waddr;
      cnt_type ram_raddr;
      cnt_type cnt;
   } ctrl_type;

endpackage

/* rtl/speck96_144_block_cipher.sv */
// Speck 96/144: one item per block, one shared round unit, one round per cycle.
// With expanded keys the result is registered on the last round, or once the
// output is free; new items are taken only in idle, so items never overlap.
// After a key write the first item also runs the 28-step schedule through the
// same round unit, then a key-fetch state before the rounds start.
// Synchronous active-high reset clears control and key registers; no clearing pass.
`include "speck96_144_block_cipher_macros.svh"

module speck96_144_block_cipher (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [95:0]                        req_tdata,  // block_x, block_y
   input  logic                               req_tuser,  // req_type
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [95:0]                        rsp_tdata,  // out_x, out_y
   input  logic                               csr_we,
   input  logic [spk_pkg::IDX_BITS-1:0]       csr_index,
   input  logic [spk_pkg::WORD_BITS-1:0]      csr_wdata
);

   localparam int W = spk_pkg::WORD_BITS;

   spk_pkg::ctrl_type ctrl;
   logic              idle;
   logic              req_fire;
   logic              rsp_free;

   spk_pkg::word_type key0_ff, key1_ff, key2_ff;
   logic              keys_ready_ff;
   spk_pkg::word_type x_ff, y_ff;
   spk_pkg::word_type k_ff, la_ff, lb_ff;
   spk_pkg::word_type out_x_ff, out_y_ff;
   logic              rsp_valid_ff;

   spk_pkg::word_type rnd_x, rnd_y, rnd_k, rnd_nx, rnd_ny;
   spk_pkg::word_type ram_wdata, ram_rdata;

   assign req_tready = idle;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   spk_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_fire   (req_fire),
      .req_op     (req_tuser),
      .keys_ready (keys_ready_ff),
      .rsp_free   (rsp_free),
      .idle       (idle),
      .ctrl       (ctrl)
   );

   // Schedule step reuses the forward round: x = l[i], y = k[i], key = i
   assign rnd_x = ctrl.exp_step ? la_ff : x_ff;
   assign rnd_y = ctrl.exp_step ? k_ff  : y_ff;
   assign rnd_k = ctrl.exp_step ? {{(W - spk_pkg::CNT_BITS){1'b0}}, ctrl.cnt} : ram_rdata;

   spk_round u_round (
      .x       (rnd_x),
      .y       (rnd_y),
      .k       (rnd_k),
      .decrypt (ctrl.decrypt),
      .nx      (rnd_nx),
      .ny      (rnd_ny)
   );

   assign ram_wdata = ctrl.wr_key0 ? key0_ff : rnd_ny;

   spk_ram #(
      .WIDTH (W),
      .DEPTH (spk_pkg::ROUNDS)
   ) u_keys (
      .clock (clock),
      .we    (ctrl.ram_we),
      .waddr (ctrl.ram_waddr),
      .wdata (ram_wdata),
      .raddr (ctrl.ram_raddr),
      .rdata (ram_rdata)
   );

   // Key registers and the expanded flag
   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff       <= '0;
         key1_ff       <= '0;
         key2_ff       <= '0;
         keys_ready_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               spk_pkg::REG_KEY0: begin
                  key0_ff       <= csr_wdata;
                  keys_ready_ff <= 1'b0;
               end
               spk_pkg::REG_KEY1: begin
                  key1_ff       <= csr_wdata;
                  keys_ready_ff <= 1'b0;
               end
               spk_pkg::REG_KEY2: begin
                  key2_ff       <= csr_wdata;
                  keys_ready_ff <= 1'b0;
               end
               default: begin
                  keys_ready_ff <= keys_ready_ff;
               end
            endcase
         end else if (ctrl.set_ready) begin
            keys_ready_ff <= 1'b1;
         end
      end
   end

   // Block and schedule words
   always_ff @(posedge clock) begin
      if (req_fire) begin
         x_ff  <= req_tdata[W-1:0];
         y_ff  <= req_tdata[2*W-1:W];
         k_ff  <= key0_ff;
         la_ff <= key1_ff;
         lb_ff <= key2_ff;
      end else if (ctrl.exp_step) begin
         la_ff <= lb_ff;
         lb_ff <= rnd_nx;
         k_ff  <= rnd_ny;
      end else if (ctrl.run_step) begin
         x_ff <= rnd_nx;
         y_ff <= rnd_ny;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (ctrl.out_load) begin
         out_x_ff <= ctrl.out_from_rnd ? rnd_nx : x_ff;
         out_y_ff <= ctrl.out_from_rnd ? rnd_ny : y_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {out_y_ff, out_x_ff};

   // Never overwrite a result that still waits
   `SPK_ASSERT_NOW(a_no_overwrite, clock, reset, ctrl.out_load, !rsp_valid_ff || rsp_tready)
   // Rounds only run on an expanded schedule
   `SPK_ASSERT_NOW(a_run_keys, clock, reset, ctrl.run_step, keys_ready_ff)
   // An item taken with stale keys starts the expansion
   `SPK_ASSERT_NEXT(a_expand, clock, reset, req_fire && !keys_ready_ff, ctrl.exp_step)

endmodule

/* rtl/spk_ram.sv */
module spk_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 29
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/spk_round.sv */
module spk_round (
   input  spk_pkg::word_type x,
   input  spk_pkg::word_type y,
   input  spk_pkg::word_type k,
   input  logic              decrypt,
   output spk_pkg::word_type nx,
   output spk_pkg::word_type ny
);

   localparam int W = spk_pkg::WORD_BITS;

   spk_pkg::word_type enc_x;
   spk_pkg::word_type enc_y;
   spk_pkg::word_type dec_x;
   spk_pkg::word_type dec_y;
   spk_pkg::word_type dec_sum;
   spk_pkg::word_type dec_diff;

   // Forward round: x = (ror8(x) + y) ^ k, y = rol3(y) ^ x
   assign enc_x = ({x[7:0], x[W-1:8]} + y) ^ k;
   assign enc_y = {y[W-4:0], y[W-1:W-3]} ^ enc_x;

   // Inverse round: y = ror3(x ^ y), x = rol8((x ^ k) - y)
   assign dec_sum  = x ^ y;
   assign dec_y    = {dec_sum[2:0], dec_sum[W-1:3]};
   assign dec_diff = (x ^ k) - dec_y;
   assign dec_x    = {dec_diff[W-9:0], dec_diff[W-1:W-8]};

   assign nx = decrypt ? dec_x : enc_x;
   assign ny = decrypt ? dec_y : enc_y;

endmodule

/* rtl/spk_ctrl.sv */
module spk_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_fire,
   input  logic              req_op,
   input  logic              keys_ready,
   input  logic              rsp_free,
   output logic              idle,
   output spk_pkg::ctrl_type ctrl
);

   localparam spk_pkg::cnt_type LAST_EXP = spk_pkg::CNT_BITS'(spk_pkg::ROUNDS - 2);
   localparam spk_pkg::cnt_type LAST_RUN = spk_pkg::CNT_BITS'(spk_pkg::ROUNDS - 1);

   spk_pkg::state_type state_ff, state_in;
   spk_pkg::cnt_type   cnt_ff, cnt_in;
   spk_pkg::op_type    op_ff, op_in;

   logic last_exp;
   logic last_run;

   // Key index of the first round for an operation
   function automatic spk_pkg::cnt_type first_idx(input spk_pkg::op_type op);
      return (op == spk_pkg::OP_DECRYPT) ? LAST_RUN : '0;
   endfunction

   assign last_exp = (cnt_ff == LAST_EXP);
   assign last_run = (cnt_ff == LAST_RUN);

   // Next state and round counter
   always_comb begin
      state_in = state_ff;
      cnt_in   = '0;
      op_in    = op_ff;
      case (state_ff)
         spk_pkg::ST_IDLE: begin
            if (req_fire) begin
               op_in    = spk_pkg::op_type'(req_op);
               state_in = keys_ready ? spk_pkg::ST_RUN : spk_pkg::ST_EXPAND;
            end
         end
         spk_pkg::ST_EXPAND: begin
            if (last_exp) begin
               state_in = spk_pkg::ST_PREP;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         spk_pkg::ST_PREP: begin
            state_in = spk_pkg::ST_RUN;
         end
         spk_pkg::ST_RUN: begin
            if (last_run) begin
               state_in = rsp_free ? spk_pkg::ST_IDLE : spk_pkg::ST_HOLD;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         spk_pkg::ST_HOLD: begin
            if (rsp_free) begin
               state_in = spk_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = spk_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath controls
   always_comb begin
      ctrl              = '0;
      ctrl.cnt          = cnt_ff;
      ctrl.decrypt      = (op_ff == spk_pkg::OP_DECRYPT);
      idle              = 1'b0;
      case (state_ff)
         spk_pkg::ST_IDLE: begin
            idle           = 1'b1;
            ctrl.ram_raddr = first_idx(spk_pkg::op_type'(req_op));
            // Store round key zero as the expansion starts
            ctrl.ram_we    = req_fire && !keys_ready;
            ctrl.wr_key0   = 1'b1;
         end
         spk_pkg::ST_EXPAND: begin
            ctrl.exp_step  = 1'b1;
            ctrl.decrypt   = 1'b0;
            ctrl.ram_we    = 1'b1;
            ctrl.ram_waddr = cnt_ff + 1'b1;
            ctrl.set_ready = last_exp;
         end
         spk_pkg::ST_PREP: begin
            ctrl.ram_raddr = first_idx(op_ff);
         end
         spk_pkg::ST_RUN: begin
            ctrl.run_step     = 1'b1;
            ctrl.out_load     = last_run && rsp_free;
            ctrl.out_from_rnd = 1'b1;
            ctrl.ram_raddr    = (op_ff == spk_pkg::OP_DECRYPT) ? (LAST_EXP - cnt_ff)
                                                               : (cnt_ff + 1'b1);
         end
         spk_pkg::ST_HOLD: begin
            ctrl.out_load = rsp_free;
         end
         default: begin
            idle = 1'b0;
         end
      endcase
   end

   // Sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spk_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      op_ff <= op_in;
   end

endmodule

/* tb/sv/speck96_144_block_cipher_tb.sv */
`timescale 1ns / 1ps

module speck96_144_block_cipher_tb;

   localparam logic [spk_pkg::IDX_BITS-1:0] IDX_UNUSED = 2'd3;
   localparam int TIMEOUT_CYCLES = 400000;
   localparam int DRAIN_CYCLES   = 80;
   localparam int HOLD_CYCLES    = 300;
   localparam int MAX_REPORTS    = 10;

   typedef struct {
      spk_pkg::word_type x;
      spk_pkg::word_type y;
   } block_words_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [95:0]                   req_tdata = '0;   // block_x, block_y
   logic                          req_tuser = 1'b0; // req_type
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [95:0]                   rsp_tdata;        // out_x, out_y
   logic                          csr_we = 1'b0;
   logic [spk_pkg::IDX_BITS-1:0]  csr_index = '0;
   logic [spk_pkg::WORD_BITS-1:0] csr_wdata = '0;

   // Shadow of the key registers and the expanded schedule
   spk_pkg::word_type key_word [3];
   spk_pkg::word_type round_key [spk_pkg::ROUNDS];
   bit                round_keys_fresh = 1'b0;

   block_words_type ciphered_q [$];
   block_words_type last_cipher;
   int         mismatch_count = 0;
   int         result_count = 0;
   int         encrypt_count = 0;
   int         decrypt_count = 0;
   int         key_set_count = 0;
   int         cycle_count = 0;
   bit         steady = 1'b0;
   bit         hold_req = 1'b0;
   int         hold_left = 0;

   speck96_144_block_cipher dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= TIMEOUT_CYCLES) begin
         $display("timeout after %0d cycles, %0d blocks outstanding",
                  cycle_count, ciphered_q.size());
         $display("speck96_144_block_cipher test failed");
         $finish;
      end
   end

   function automatic spk_pkg::word_type rotl(spk_pkg::word_type v, int r);
      return (v << r) | (v >> (spk_pkg::WORD_BITS - r));
   endfunction

   function automatic spk_pkg::word_type rotr(spk_pkg::word_type v, int r);
      return (v >> r) | (v << (spk_pkg::WORD_BITS - r));
   endfunction

   // Build the 29 round keys from the three key words
   function automatic void expand_round_keys();
      spk_pkg::word_type k;
      spk_pkg::word_type l [spk_pkg::ROUNDS+1];
      k = key_word[0];
      l[0] = key_word[1];
      l[1] = key_word[2];
      round_key[0] = k;
      for (int i = 0; i < spk_pkg::ROUNDS - 1; i++) begin
         l[i+2] = (k + rotr(l[i], 8)) ^ spk_pkg::word_type'(i);
         k = rotl(k, 3) ^ l[i+2];
         round_key[i+1] = k;
      end
      round_keys_fresh = 1'b1;
   endfunction

   // Run one block through the full cipher in either direction
   function automatic block_words_type speck_apply(spk_pkg::op_type op,
                                                   spk_pkg::word_type bx,
                                                   spk_pkg::word_type by);
      block_words_type r;
      spk_pkg::word_type x;
      spk_pkg::word_type y;
      x = bx;
      y = by;
      if (!round_keys_fresh) expand_round_keys();
      if (op == spk_pkg::OP_ENCRYPT) begin
         for (int i = 0; i < spk_pkg::ROUNDS; i++) begin
            x = (rotr(x, 8) + y) ^ round_key[i];
            y = rotl(y, 3) ^ x;
         end
      end else begin
         for (int i = 0; i < spk_pkg::ROUNDS; i++) begin
            y = rotr(x ^ y, 3);
            x = rotl((x ^ round_key[spk_pkg::ROUNDS-1-i]) - y, 8);
         end
      end
      r.x = x;
      r.y = y;
      return r;
   endfunction

   function automatic spk_pkg::word_type rand_word();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return spk_pkg::word_type'({$urandom, $urandom});
      endcase
   endfunction

   function automatic void note_mismatch(string what, spk_pkg::word_type want,
                                         spk_pkg::word_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("mismatch on %s at cycle %0d: expected %012h, got %012h",
                  what, cycle_count, want, got);
   endfunction

   // Check each result item and drive the result-side ready
   always @(posedge clock) begin
      block_words_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         result_count++;
         if (ciphered_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected result item at cycle %0d: %024h",
                        cycle_count, rsp_tdata);
         end else begin
            want = ciphered_q.pop_front();
            if (rsp_tdata[47:0] !== want.x) note_mismatch("out_x", want.x, rsp_tdata[47:0]);
            if (rsp_tdata[95:48] !== want.y) note_mismatch("out_y", want.y, rsp_tdata[95:48]);
         end
      end
      if (hold_req) begin
         hold_left = HOLD_CYCLES;
         hold_req = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (steady || reset) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= 29);
      end
   end

   // Write one register; index out of range is ignored by the block
   task automatic write_reg(logic [spk_pkg::IDX_BITS-1:0] idx, spk_pkg::word_type val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         spk_pkg::REG_KEY0: key_word[0] = val;
         spk_pkg::REG_KEY1: key_word[1] = val;
         spk_pkg::REG_KEY2: key_word[2] = val;
         default: ;
      endcase
      if (idx != IDX_UNUSED) round_keys_fresh = 1'b0;
      @(posedge clock);
   endtask

   task automatic load_key(spk_pkg::word_type k0, spk_pkg::word_type k1,
                           spk_pkg::word_type k2);
      write_reg(spk_pkg::REG_KEY0, k0);
      write_reg(spk_pkg::REG_KEY1, k1);
      write_reg(spk_pkg::REG_KEY2, k2);
      key_set_count++;
   endtask

   // Offer one block and wait until it is taken
   task automatic send_block(spk_pkg::op_type op, spk_pkg::word_type bx,
                             spk_pkg::word_type by);
      int gap;
      gap = 0;
      if (!steady && $urandom_range(99) < 29) gap = $urandom_range(1, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {by, bx};
      do @(posedge clock); while (req_tready !== 1'b1);
      ciphered_q.push_back(speck_apply(op, bx, by));
      if (op == spk_pkg::OP_ENCRYPT) begin
         encrypt_count++;
         last_cipher = ciphered_q[$];
      end else begin
         decrypt_count++;
      end
   endtask

   // Drop valid and wait for every outstanding result
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (ciphered_q.size() != 0);
   endtask

   task automatic test_reset_keys();
      send_block(spk_pkg::OP_ENCRYPT, '0, '0);
      send_block(spk_pkg::OP_DECRYPT, '1, '1);
      send_block(spk_pkg::OP_ENCRYPT, '0, '1);
      drain();
   endtask

   task automatic test_unused_index();
      write_reg(IDX_UNUSED, '1);
      send_block(spk_pkg::OP_ENCRYPT, 48'h123456789abc, 48'hfedcba987654);
      drain();
   endtask

   task automatic test_known_vector();
      load_key(48'h050403020100, 48'h0d0c0b0a0908, 48'h151413121110);
      send_block(spk_pkg::OP_ENCRYPT, 48'h656d6974206e, 48'h69202c726576);
      send_block(spk_pkg::OP_DECRYPT, 48'h2bf31072228a, 48'h7ae440252ee6);
      drain();
   endtask

   task automatic test_key_extremes();
      load_key('1, '1, '1);
      send_block(spk_pkg::OP_ENCRYPT, '0, '0);
      send_block(spk_pkg::OP_ENCRYPT, '1, '1);
      send_block(spk_pkg::OP_DECRYPT, 48'h555555555555, 48'haaaaaaaaaaaa);
      send_block(spk_pkg::OP_DECRYPT, 48'haaaaaaaaaaaa, 48'h555555555555);
      drain();
      load_key('0, '0, '1);
      send_block(spk_pkg::OP_ENCRYPT, 48'h800000000001, 48'h000000000001);
      send_block(spk_pkg::OP_DECRYPT, last_cipher.x, last_cipher.y);
      drain();
   endtask

   // A single-register write must force a new schedule
   task automatic test_single_key_update();
      write_reg(spk_pkg::REG_KEY1, 48'h8000_0000_0000);
      send_block(spk_pkg::OP_ENCRYPT, 48'h0123456789ab, 48'hcdef01234567);
      drain();
      write_reg(spk_pkg::REG_KEY0, 48'h0000_0000_0001);
      send_block(spk_pkg::OP_DECRYPT, 48'h0123456789ab, 48'hcdef01234567);
      drain();
   endtask

   task automatic traffic_phase(int count);
      spk_pkg::op_type op;
      for (int n = 0; n < count; n++) begin
         op = spk_pkg::op_type'($urandom_range(1));
         // now and then decrypt a recent ciphertext for a round trip
         if (encrypt_count > 0 && $urandom_range(7) == 0)
            send_block(spk_pkg::OP_DECRYPT, last_cipher.x, last_cipher.y);
         else
            send_block(op, rand_word(), rand_word());
      end
      drain();
   endtask

   task automatic test_random_traffic();
      load_key(rand_word(), rand_word(), rand_word());
      traffic_phase(110);
      load_key('1, '1, '1);
      traffic_phase(100);
      load_key('0, '0, '0);
      traffic_phase(100);
      load_key(spk_pkg::word_type'({$urandom, $urandom}),
               spk_pkg::word_type'({$urandom, $urandom}),
               spk_pkg::word_type'({$urandom, $urandom}));
      steady = 1'b1;
      traffic_phase(120);
      steady = 1'b0;
      write_reg(spk_pkg::REG_KEY2, spk_pkg::word_type'({$urandom, $urandom}));
      traffic_phase(100);
      load_key(rand_word(), rand_word(), rand_word());
      traffic_phase(100);
   endtask

   // Hold the result side off while blocks keep arriving
   task automatic test_output_stall();
      hold_req = 1'b1;
      for (int n = 0; n < 14; n++)
         send_block(spk_pkg::op_type'($urandom_range(1)), rand_word(), rand_word());
      drain();
   endtask

   initial begin
      key_word[0] = '0;
      key_word[1] = '0;
      key_word[2] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_keys();
      test_unused_index();
      test_known_vector();
      test_key_extremes();
      test_single_key_update();
      test_random_traffic();
      test_output_stall();

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d encrypt and %0d decrypt blocks over %0d key loads, %0d results checked",
               encrypt_count, decrypt_count, key_set_count, result_count);
      $display("included reset-value keys, ignored register index, a %0d-cycle output stall",
               HOLD_CYCLES);
      if (mismatch_count == 0 && ciphered_q.size() == 0) begin
         $display("speck96_144_block_cipher test passed");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatch_count, ciphered_q.size());
         $display("speck96_144_block_cipher test failed");
      end
      $finish;
   end

endmodule
